// ----- sv/leb_pkg.sv -----
// Shared constants and codes for the line edit buffer.
package leb_pkg;

    // Default character store size.
    localparam int CAPACITY_DEF = 256;

    // Scroll window width after reset.
    localparam logic [7:0] WIDTH_RESET = 8'd32;

    // Printable character range.
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    // Request codes.
    localparam logic [3:0] REQ_INSERT    = 4'd0;
    localparam logic [3:0] REQ_BACKSPACE = 4'd1;
    localparam logic [3:0] REQ_DELETE    = 4'd2;
    localparam logic [3:0] REQ_DELKEY    = 4'd3;
    localparam logic [3:0] REQ_LEFT      = 4'd4;
    localparam logic [3:0] REQ_RIGHT     = 4'd5;
    localparam logic [3:0] REQ_HOME      = 4'd6;
    localparam logic [3:0] REQ_END       = 4'd7;
    localparam logic [3:0] REQ_CLEAR     = 4'd8;
    localparam logic [3:0] REQ_READ      = 4'd9;

    // Status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOOP  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

endpackage

// ----- sv/leb_store.sv -----
// Character store: one write port and one read port with registered read data.
module leb_store #(
    parameter int CAPACITY = leb_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [CAPACITY];
    logic [7:0] rdata_reg;

    // Write one entry and register the read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/line_edit_buffer_unit.sv -----
// Top level of the line edit buffer: sequencer, cursor state and scroll tracking.
//
//  channel   | signals                                       | timing
//  ----------+-----------------------------------------------+---------------------------
//  request   | start, busy, req_type, char_code, read_index  | transfer when start && !busy
//  result    | done, cursor_pos, text_len, scroll_pos,       | valid for the one cycle
//            | read_char, status                             | that done is high
//  config    | cfg_we, cfg_data (visible_width)              | written when cfg_we is high
//
// A move or end request passes decode, follow and report; home, clear and rejected
// requests go from decode to report, and a read passes decode, read wait and report.
// An insert or delete walks the tail through the single store port pair with one
// shared step counter, then passes commit, follow and report.
// Reset clears length, cursor and scroll at once; the store needs no clearing pass.
// The result is shown for one cycle only; the receiver cannot stall it.
module line_edit_buffer_unit #(
    parameter int CAPACITY = leb_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [3:0] req_type,
    input  logic [7:0] char_code,
    input  logic [7:0] read_index,
    output logic       done,
    output logic [8:0] cursor_pos,
    output logic [8:0] text_len,
    output logic [8:0] scroll_pos,
    output logic [7:0] read_char,
    output logic [1:0] status,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ((CW > 8) ? CW : 8) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_COMMIT,
        S_FOLLOW,
        S_READ_WAIT,
        S_REPORT
    } state_t;

    state_t        state_reg;
    logic [3:0]    req_reg;
    logic [7:0]    chr_reg;
    logic [7:0]    idx_reg;
    logic [7:0]    width_reg;
    logic [CW-1:0] length_reg;
    logic [CW-1:0] cursor_reg;
    logic [CW-1:0] scroll_reg;
    logic [CW-1:0] scroll_next;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] src_reg;
    logic [AW-1:0] dst_reg;
    logic          pend_reg;
    logic          up_reg;
    logic          ins_reg;
    logic [1:0]    status_reg;
    logic [7:0]    rd_char_reg;
    logic [8:0]    cursor_pos_reg;
    logic [8:0]    text_len_reg;
    logic [8:0]    scroll_pos_reg;
    logic [7:0]    read_char_reg;
    logic [1:0]    status_out_reg;
    logic          done_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    logic          is_print;
    logic          at_end;
    logic          sel_bs;
    logic          is_full;
    logic          idx_ok;
    logic [EW-1:0] width_e;
    logic [EW-1:0] cursor_e;
    logic [EW-1:0] scroll_e;

    leb_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Decode helpers on the captured request.
    assign is_print = (chr_reg >= leb_pkg::PRINT_LO) && (chr_reg <= leb_pkg::PRINT_HI);
    assign at_end   = (cursor_reg == length_reg);
    assign sel_bs   = (req_reg == leb_pkg::REQ_BACKSPACE)
                   || ((req_reg == leb_pkg::REQ_DELKEY) && at_end);
    assign is_full  = (length_reg == CW'(CAPACITY)) || (cursor_reg > length_reg);
    assign idx_ok   = EW'(idx_reg) < EW'(length_reg);

    // Keep the cursor inside the window; a zero width counts as one.
    assign width_e  = (width_reg == 8'd0) ? EW'(1) : EW'(width_reg);
    assign cursor_e = EW'(cursor_reg);
    assign scroll_e = EW'(scroll_reg);

    always_comb
    begin
        if (cursor_e < scroll_e)
        begin
            scroll_next = cursor_reg;
        end
        else if (cursor_e >= scroll_e + width_e)
        begin
            scroll_next = CW'(cursor_e - width_e + EW'(1));
        end
        else
        begin
            scroll_next = scroll_reg;
        end
    end

    // Steer the store ports from the sequencer state.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = dst_reg;
        mem_wdata = mem_rdata;
        mem_raddr = src_reg;
        unique case (state_reg)
            S_DECODE:
            begin
                mem_raddr = AW'(idx_reg);
            end
            S_SHIFT:
            begin
                mem_we = pend_reg;
            end
            S_COMMIT:
            begin
                if (ins_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(cursor_reg);
                    mem_wdata = chr_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Hold the window width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= leb_pkg::WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            width_reg <= cfg_data;
        end
    end

    // Sequencer with buffer state and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= '0;
            chr_reg        <= '0;
            idx_reg        <= '0;
            length_reg     <= '0;
            cursor_reg     <= '0;
            scroll_reg     <= '0;
            cnt_reg        <= '0;
            src_reg        <= '0;
            dst_reg        <= '0;
            pend_reg       <= 1'b0;
            up_reg         <= 1'b0;
            ins_reg        <= 1'b0;
            status_reg     <= leb_pkg::ST_DONE;
            rd_char_reg    <= '0;
            cursor_pos_reg <= '0;
            text_len_reg   <= '0;
            scroll_pos_reg <= '0;
            read_char_reg  <= '0;
            status_out_reg <= leb_pkg::ST_DONE;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    // Take a request transfer.
                    if (start)
                    begin
                        req_reg     <= req_type;
                        chr_reg     <= char_code;
                        idx_reg     <= read_index;
                        status_reg  <= leb_pkg::ST_DONE;
                        rd_char_reg <= '0;
                        pend_reg    <= 1'b0;
                        state_reg   <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    unique case (req_reg)
                        leb_pkg::REQ_INSERT:
                        begin
                            if (!is_print)
                            begin
                                status_reg <= leb_pkg::ST_NOOP;
                                state_reg  <= S_REPORT;
                            end
                            else if (is_full)
                            begin
                                status_reg <= leb_pkg::ST_FULL;
                                state_reg  <= S_REPORT;
                            end
                            else
                            begin
                                // Open a gap at the cursor, top entry first.
                                cnt_reg   <= length_reg - cursor_reg;
                                src_reg   <= AW'(length_reg - CW'(1));
                                up_reg    <= 1'b1;
                                ins_reg   <= 1'b1;
                                state_reg <= S_SHIFT;
                            end
                        end
                        leb_pkg::REQ_BACKSPACE, leb_pkg::REQ_DELETE, leb_pkg::REQ_DELKEY:
                        begin
                            if (sel_bs)
                            begin
                                if ((cursor_reg == '0) || (length_reg == '0))
                                begin
                                    status_reg <= leb_pkg::ST_NOOP;
                                    state_reg  <= S_REPORT;
                                end
                                else
                                begin
                                    // Drop the entry before the cursor.
                                    cursor_reg <= cursor_reg - CW'(1);
                                    cnt_reg    <= length_reg - cursor_reg;
                                    src_reg    <= AW'(cursor_reg);
                                    up_reg     <= 1'b0;
                                    ins_reg    <= 1'b0;
                                    state_reg  <= S_SHIFT;
                                end
                            end
                            else if (cursor_reg >= length_reg)
                            begin
                                status_reg <= leb_pkg::ST_NOOP;
                                state_reg  <= S_REPORT;
                            end
                            else
                            begin
                                // Drop the entry at the cursor.
                                cnt_reg   <= length_reg - cursor_reg - CW'(1);
                                src_reg   <= AW'(cursor_reg + CW'(1));
                                up_reg    <= 1'b0;
                                ins_reg   <= 1'b0;
                                state_reg <= S_SHIFT;
                            end
                        end
                        leb_pkg::REQ_LEFT:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_reg <= cursor_reg - CW'(1);
                                state_reg  <= S_FOLLOW;
                            end
                            else
                            begin
                                status_reg <= leb_pkg::ST_NOOP;
                                state_reg  <= S_REPORT;
                            end
                        end
                        leb_pkg::REQ_RIGHT:
                        begin
                            if (cursor_reg < length_reg)
                            begin
                                cursor_reg <= cursor_reg + CW'(1);
                                state_reg  <= S_FOLLOW;
                            end
                            else
                            begin
                                status_reg <= leb_pkg::ST_NOOP;
                                state_reg  <= S_REPORT;
                            end
                        end
                        leb_pkg::REQ_HOME:
                        begin
                            cursor_reg <= '0;
                            scroll_reg <= '0;
                            state_reg  <= S_REPORT;
                        end
                        leb_pkg::REQ_END:
                        begin
                            cursor_reg <= length_reg;
                            state_reg  <= S_FOLLOW;
                        end
                        leb_pkg::REQ_CLEAR:
                        begin
                            length_reg <= '0;
                            cursor_reg <= '0;
                            scroll_reg <= '0;
                            state_reg  <= S_REPORT;
                        end
                        leb_pkg::REQ_READ:
                        begin
                            // The store read was issued this cycle.
                            if (idx_ok)
                            begin
                                state_reg <= S_READ_WAIT;
                            end
                            else
                            begin
                                status_reg <= leb_pkg::ST_RANGE;
                                state_reg  <= S_REPORT;
                            end
                        end
                        default:
                        begin
                            status_reg <= leb_pkg::ST_NOOP;
                            state_reg  <= S_REPORT;
                        end
                    endcase
                end
                S_SHIFT:
                begin
                    // Read one entry per cycle; its move lands the next cycle.
                    if (cnt_reg != '0)
                    begin
                        dst_reg  <= up_reg ? (src_reg + AW'(1)) : (src_reg - AW'(1));
                        src_reg  <= up_reg ? (src_reg - AW'(1)) : (src_reg + AW'(1));
                        cnt_reg  <= cnt_reg - CW'(1);
                        pend_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT:
                begin
                    if (ins_reg)
                    begin
                        length_reg <= length_reg + CW'(1);
                        cursor_reg <= cursor_reg + CW'(1);
                    end
                    else
                    begin
                        length_reg <= length_reg - CW'(1);
                    end
                    state_reg <= S_FOLLOW;
                end
                S_FOLLOW:
                begin
                    scroll_reg <= scroll_next;
                    state_reg  <= S_REPORT;
                end
                S_READ_WAIT:
                begin
                    rd_char_reg <= mem_rdata;
                    state_reg   <= S_REPORT;
                end
                S_REPORT:
                begin
                    cursor_pos_reg <= 9'(cursor_reg);
                    text_len_reg   <= 9'(length_reg);
                    scroll_pos_reg <= 9'(scroll_reg);
                    read_char_reg  <= rd_char_reg;
                    status_out_reg <= status_reg;
                    done_reg       <= 1'b1;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign cursor_pos = cursor_pos_reg;
    assign text_len   = text_len_reg;
    assign scroll_pos = scroll_pos_reg;
    assign read_char  = read_char_reg;
    assign status     = status_out_reg;

endmodule

// ----- sv/leb_check.sv -----
// Port-level checks for the line edit buffer, bound to the top level.
module leb_check #(
    parameter int CAPACITY = leb_pkg::CAPACITY_DEF
) (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [8:0] cursor_pos,
    input logic [8:0] text_len,
    input logic [8:0] scroll_pos,
    input logic [7:0] read_char,
    input logic [1:0] status
);

    localparam bit SMALL = (CAPACITY < 512);

    // A transfer makes the block busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request transfer did not raise busy");

    // A result only follows a busy cycle.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding work");

    // Cursor stays inside the text and the window start never passes it.
    a_cursor_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && SMALL) |-> ((cursor_pos <= text_len) && (scroll_pos <= cursor_pos)))
        else $error("cursor, scroll and length out of order");

    // A full report means the store is at capacity.
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && SMALL && (status == leb_pkg::ST_FULL)) |-> (text_len == 9'(CAPACITY)))
        else $error("full status with free space");

    // An out-of-range read returns no character.
    a_range_char: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == leb_pkg::ST_RANGE)) |-> (read_char == 8'd0))
        else $error("out-of-range read returned data");

endmodule

bind line_edit_buffer_unit leb_check #(
    .CAPACITY (CAPACITY)
) u_leb_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .cursor_pos (cursor_pos),
    .text_len   (text_len),
    .scroll_pos (scroll_pos),
    .read_char  (read_char),
    .status     (status)
);
